FILE: hdl/jptj_pkg.sv
// jptj_pkg: shared types and constants of the pan/tilt jog controller
// item layouts, register map, reset values and pulse scaling
// depends on nothing
package jptj_pkg;

  // one control sample
  typedef struct packed {
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic        pad_left;
    logic        pad_right;
    logic        pad_up;
    logic        pad_down;
    logic        recenter_held;
    logic [31:0] now_ms;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [8:0]  pan_angle_out;
    logic [8:0]  tilt_angle_out;
    logic [11:0] pan_pulse_us;
    logic [11:0] tilt_pulse_us;
    logic        write_strobe;
    logic        drive_enabled;
  } out_item_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic signed [5:0] pan_delta;
    logic signed [5:0] tilt_delta;
    logic              recenter;
    logic              active;
    logic [31:0]       now_ms;
  } jog_cmd_t;

  // configuration registers
  typedef struct packed {
    logic [8:0]  pan_center;
    logic [8:0]  pan_min;
    logic [8:0]  pan_max;
    logic [8:0]  tilt_center;
    logic [8:0]  tilt_min;
    logic [8:0]  tilt_max;
    logic [15:0] idle_timeout_ms;
    logic [3:0]  pad_step;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_PAN_CENTER  = 3'd0,
    REG_PAN_MIN     = 3'd1,
    REG_PAN_MAX     = 3'd2,
    REG_TILT_CENTER = 3'd3,
    REG_TILT_MIN    = 3'd4,
    REG_TILT_MAX    = 3'd5,
    REG_IDLE_TMO    = 3'd6,
    REG_PAD_STEP    = 3'd7
  } cfg_idx_t;

  localparam logic [8:0]  RST_PAN_CENTER  = 9'd143;
  localparam logic [8:0]  RST_PAN_MIN     = 9'd14;
  localparam logic [8:0]  RST_PAN_MAX     = 9'd270;
  localparam logic [8:0]  RST_TILT_CENTER = 9'd270;
  localparam logic [8:0]  RST_TILT_MIN    = 9'd180;
  localparam logic [8:0]  RST_TILT_MAX    = 9'd360;
  localparam logic [15:0] RST_IDLE_TMO    = 16'd3000;
  localparam logic [3:0]  RST_PAD_STEP    = 4'd3;

  // angle*2000/360 = angle*50/9, done as angle*ceil(50*2^16/9) >> 16
  localparam logic [18:0] PULSE_RECIP = 19'd364089;
  localparam logic [11:0] PULSE_BASE  = 12'd500;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

endpackage

FILE: hdl/jptj_queue.sv
// jptj_queue: small register-based fifo used between and after the stages
// data width and depth (power of two) set by parameters
// depends on nothing
module jptj_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [W-1:0]               wr_data,
  input  logic                       rd_en,
  output logic [W-1:0]               rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;

endmodule

FILE: hdl/jptj_front.sv
// jptj_front: accepts control samples and turns them into jog commands
// stick dead-zone classification and pad step summing
// depends on jptj_pkg
module jptj_front #(
  parameter int DEAD_BAND = 30
) (
  input  jptj_pkg::in_item_t  in_item,
  input  logic                push,
  output logic                full,
  input  logic [3:0]          pad_step,
  input  logic                cmd_full,
  output logic                cmd_wr,
  output jptj_pkg::jog_cmd_t  cmd
);

  import jptj_pkg::*;

  localparam int LO = 128 - DEAD_BAND;
  localparam int HI = 128 + DEAD_BAND;
  localparam int SPAN_HI = 255 - HI;

  localparam logic [7:0] LO_V = 8'(LO);
  localparam logic [7:0] HI_V = 8'(HI);
  // thresholds on 3*distance for speeds 1, 2, 3
  localparam logic [9:0] LO_T1 = 10'(LO);
  localparam logic [9:0] LO_T2 = 10'(2 * LO);
  localparam logic [9:0] LO_T3 = 10'(3 * LO);
  localparam logic [9:0] HI_T1 = 10'(SPAN_HI);
  localparam logic [9:0] HI_T2 = 10'(2 * SPAN_HI);
  localparam logic [9:0] HI_T3 = 10'(3 * SPAN_HI);

  logic x_below, x_above, y_below, y_above;
  logic [1:0] x_mag, y_mag;
  logic signed [5:0] step_s, x_speed, y_speed;

  // truncating speed map as a count of thresholds passed
  function automatic logic [1:0] speed_mag(input logic below, input logic [7:0] v);
    logic [7:0] d;
    logic [9:0] d3;
    logic [9:0] t1, t2, t3;
    d  = below ? (LO_V - v) : (v - HI_V);
    d3 = {2'b00, d} + {1'b0, d, 1'b0};
    t1 = below ? LO_T1 : HI_T1;
    t2 = below ? LO_T2 : HI_T2;
    t3 = below ? LO_T3 : HI_T3;
    speed_mag = 2'({1'b0, d3 >= t1} + {1'b0, d3 >= t2} + {1'b0, d3 >= t3});
  endfunction

  assign x_below = in_item.stick_x < LO_V;
  assign x_above = in_item.stick_x > HI_V;
  assign y_below = in_item.stick_y < LO_V;
  assign y_above = in_item.stick_y > HI_V;

  assign x_mag = speed_mag(x_below, in_item.stick_x);
  assign y_mag = speed_mag(y_below, in_item.stick_y);

  assign step_s = $signed({2'b00, pad_step});

  // pan follows the stick, tilt runs opposite to it
  always_comb begin
    x_speed = '0;
    y_speed = '0;
    if (x_below) begin
      x_speed = -$signed({4'b0000, x_mag});
    end else if (x_above) begin
      x_speed = $signed({4'b0000, x_mag});
    end
    if (y_below) begin
      y_speed = $signed({4'b0000, y_mag});
    end else if (y_above) begin
      y_speed = -$signed({4'b0000, y_mag});
    end
  end

  always_comb begin
    cmd.pan_delta  = x_speed
                   + (in_item.pad_right ? step_s : 6'sd0)
                   - (in_item.pad_left  ? step_s : 6'sd0);
    cmd.tilt_delta = y_speed
                   + (in_item.pad_up    ? step_s : 6'sd0)
                   - (in_item.pad_down  ? step_s : 6'sd0);
    cmd.recenter   = in_item.recenter_held;
    cmd.active     = x_below | x_above | y_below | y_above
                   | in_item.pad_left | in_item.pad_right
                   | in_item.pad_up | in_item.pad_down
                   | in_item.recenter_held;
    cmd.now_ms     = in_item.now_ms;
  end

  assign full   = cmd_full;
  assign cmd_wr = push & ~cmd_full;

endmodule

FILE: hdl/jptj_back.sv
// jptj_back: applies jog commands to the angle and drive state
// clamp, idle timeout, pulse scaling and the result fifo
// depends on jptj_pkg, jptj_queue
module jptj_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jptj_pkg::cfg_t      cfg,
  input  logic                cmd_empty,
  input  jptj_pkg::jog_cmd_t  cmd,
  output logic                cmd_rd,
  output jptj_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop
);

  import jptj_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH) + 1;

  typedef struct packed {
    logic [8:0] pan;
    logic [8:0] tilt;
    logic       strobe;
    logic       drive;
  } upd_t;

  logic [8:0]  pan_r, pan_nxt;
  logic [8:0]  tilt_r, tilt_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic        drive_r, drive_nxt;
  logic        upd_vld_r;
  upd_t        upd_r, upd_nxt;

  logic [OCW-1:0] out_count;
  logic [OCW:0]   in_flight;
  logic           out_full;
  logic           out_rd;
  out_item_t      res;
  logic [27:0]    pan_prod, tilt_prod;
  logic [31:0]    elapsed;

  function automatic logic [8:0] apply_jog(input logic [8:0] ang,
                                           input logic signed [5:0] delta,
                                           input logic rc,
                                           input logic [8:0] center,
                                           input logic [8:0] lo,
                                           input logic [8:0] hi);
    logic signed [10:0] sum;
    sum = $signed({2'b00, ang}) + $signed({{5{delta[5]}}, delta});
    if (rc) begin
      sum = $signed({2'b00, center});
    end
    if (sum < $signed({2'b00, lo})) begin
      apply_jog = lo;
    end else if (sum > $signed({2'b00, hi})) begin
      apply_jog = hi;
    end else begin
      apply_jog = sum[8:0];
    end
  endfunction

  // take a command only with room reserved for it in the result fifo
  assign in_flight = {1'b0, out_count} + {{OCW{1'b0}}, upd_vld_r};
  assign cmd_rd    = ~cmd_empty & (in_flight < (OCW+1)'(OUT_DEPTH));

  assign elapsed = cmd.now_ms - stamp_r;

  always_comb begin
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    stamp_nxt = stamp_r;
    drive_nxt = drive_r;
    if (cmd_rd) begin
      pan_nxt  = apply_jog(pan_r, cmd.pan_delta, cmd.recenter,
                           cfg.pan_center, cfg.pan_min, cfg.pan_max);
      tilt_nxt = apply_jog(tilt_r, cmd.tilt_delta, cmd.recenter,
                           cfg.tilt_center, cfg.tilt_min, cfg.tilt_max);
      if (cmd.active) begin
        drive_nxt = 1'b1;
        stamp_nxt = cmd.now_ms;
      end else if (elapsed > {16'h0000, cfg.idle_timeout_ms}) begin
        drive_nxt = 1'b0;
      end
    end
    upd_nxt.pan    = pan_nxt;
    upd_nxt.tilt   = tilt_nxt;
    upd_nxt.strobe = cmd.active;
    upd_nxt.drive  = drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r     <= RST_PAN_CENTER;
      tilt_r    <= RST_TILT_CENTER;
      stamp_r   <= '0;
      drive_r   <= 1'b1;
      upd_vld_r <= 1'b0;
    end else begin
      pan_r     <= pan_nxt;
      tilt_r    <= tilt_nxt;
      stamp_r   <= stamp_nxt;
      drive_r   <= drive_nxt;
      upd_vld_r <= cmd_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_rd) begin
      upd_r <= upd_nxt;
    end
  end

  // pulse scaling on the way into the result fifo
  assign pan_prod  = {19'd0, upd_r.pan} * {9'd0, PULSE_RECIP};
  assign tilt_prod = {19'd0, upd_r.tilt} * {9'd0, PULSE_RECIP};

  always_comb begin
    res.pan_angle_out  = upd_r.pan;
    res.tilt_angle_out = upd_r.tilt;
    res.pan_pulse_us   = pan_prod[27:16] + PULSE_BASE;
    res.tilt_pulse_us  = tilt_prod[27:16] + PULSE_BASE;
    res.write_strobe   = upd_r.strobe;
    res.drive_enabled  = upd_r.drive;
  end

  assign out_rd = pop & ~empty;

  jptj_queue #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (upd_vld_r),
    .wr_data (res),
    .rd_en   (out_rd),
    .rd_data (out_item),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  // reservation keeps the fifo from filling past its depth
  logic unused_full;
  assign unused_full = out_full;

endmodule

FILE: hdl/joystick_pan_tilt_jog.sv
// joystick_pan_tilt_jog: top level of the stick/pad pan-tilt jog controller
// holds the register file and ties front, command queue and back together
// depends on jptj_pkg, jptj_queue, jptj_front, jptj_back
//
//   channel   handshake            payload      direction
//   -------   ------------------   ----------   ---------
//   input     push / full          in_item      into block
//   result    empty / pop          out_item     out of block
//   config    psel penable pwrite  paddr pwdata write, prdata read
//
// one item per cycle sustained while pop keeps up; an item passes the
// command queue, state update register and result fifo to out_item
// the state feedback loop is the angle add/clamp and idle compare in the back
// synchronous active-low reset restores register defaults, centre angles,
// a zero activity stamp and an enabled drive
// full rises only when the two-entry command queue backs up behind a
// stalled result side; the result fifo holds four items
module joystick_pan_tilt_jog #(
  parameter int DEAD_BAND = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  jptj_pkg::in_item_t  in_item,
  // result channel
  output logic                empty,
  input  logic                pop,
  output jptj_pkg::out_item_t out_item,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import jptj_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  cfg_idx_t reg_idx;
  logic     reg_wr;

  logic     cmd_wr, cmd_rd, cmd_full, cmd_empty;
  jog_cmd_t cmd_in, cmd_out;
  logic [$clog2(MID_DEPTH):0] cmd_count;

  // register file, word addressed
  assign pready  = 1'b1;
  assign reg_idx = cfg_idx_t'(paddr[4:2]);
  assign reg_wr  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      unique case (reg_idx)
        REG_PAN_CENTER:  cfg_nxt.pan_center      = pwdata[8:0];
        REG_PAN_MIN:     cfg_nxt.pan_min         = pwdata[8:0];
        REG_PAN_MAX:     cfg_nxt.pan_max         = pwdata[8:0];
        REG_TILT_CENTER: cfg_nxt.tilt_center     = pwdata[8:0];
        REG_TILT_MIN:    cfg_nxt.tilt_min        = pwdata[8:0];
        REG_TILT_MAX:    cfg_nxt.tilt_max        = pwdata[8:0];
        REG_IDLE_TMO:    cfg_nxt.idle_timeout_ms = pwdata[15:0];
        REG_PAD_STEP:    cfg_nxt.pad_step        = pwdata[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAN_CENTER:  prdata = {23'h0, cfg_r.pan_center};
      REG_PAN_MIN:     prdata = {23'h0, cfg_r.pan_min};
      REG_PAN_MAX:     prdata = {23'h0, cfg_r.pan_max};
      REG_TILT_CENTER: prdata = {23'h0, cfg_r.tilt_center};
      REG_TILT_MIN:    prdata = {23'h0, cfg_r.tilt_min};
      REG_TILT_MAX:    prdata = {23'h0, cfg_r.tilt_max};
      REG_IDLE_TMO:    prdata = {16'h0, cfg_r.idle_timeout_ms};
      REG_PAD_STEP:    prdata = {28'h0, cfg_r.pad_step};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_center      <= RST_PAN_CENTER;
      cfg_r.pan_min         <= RST_PAN_MIN;
      cfg_r.pan_max         <= RST_PAN_MAX;
      cfg_r.tilt_center     <= RST_TILT_CENTER;
      cfg_r.tilt_min        <= RST_TILT_MIN;
      cfg_r.tilt_max        <= RST_TILT_MAX;
      cfg_r.idle_timeout_ms <= RST_IDLE_TMO;
      cfg_r.pad_step        <= RST_PAD_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: dead zone, speed map and pad steps folded into signed deltas
  jptj_front #(
    .DEAD_BAND (DEAD_BAND)
  ) u_front (
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .pad_step (cfg_r.pad_step),
    .cmd_full (cmd_full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in)
  );

  // command queue decouples sample intake from the state update
  jptj_queue #(
    .W     ($bits(jog_cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  // back: angle state, clamp, idle timer, pulse widths, result fifo
  jptj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_rd    (cmd_rd),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

  // queue occupancy is carried by full/empty alone
  logic [$clog2(MID_DEPTH):0] unused_cmd_count;
  assign unused_cmd_count = cmd_count;

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for the joystick pan/tilt jog controller
// drives control samples and register writes, predicts every result in-bench
// depends on jptj_pkg and joystick_pan_tilt_jog
`timescale 1ns / 100ps

module tb;
  import jptj_pkg::*;

  localparam int DEAD_BAND  = 30;
  localparam int ZONE_LO    = 128 - DEAD_BAND;
  localparam int ZONE_HI    = 128 + DEAD_BAND;
  localparam int QUIET_MAX  = 4000;   // cycles with no handshake at all before giving up
  localparam int SHOWN_MAX  = 10;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // block ports, every input driven to a known value from time zero
  logic        push    = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop     = 1'b0;
  out_item_t   out_item;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  joystick_pan_tilt_jog #(
    .DEAD_BAND(DEAD_BAND)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // in-bench copy of the controller: registers and jog state
  // ---------------------------------------------------------------------------
  cfg_t        jog_cfg = '{RST_PAN_CENTER, RST_PAN_MIN, RST_PAN_MAX,
                           RST_TILT_CENTER, RST_TILT_MIN, RST_TILT_MAX,
                           RST_IDLE_TMO, RST_PAD_STEP};
  int          pan_deg   = RST_PAN_CENTER;
  int          tilt_deg  = RST_TILT_CENTER;
  logic [31:0] move_stamp = '0;
  logic        drive_on   = 1'b1;

  // results still owed by the block, oldest first
  out_item_t   owed_results[$];

  int          mismatches   = 0;
  int          quiet_cycles = 0;
  logic [31:0] sample_clock = '0;   // running millisecond stamp for random samples

  // pacing knobs, flipped by the tests
  logic        send_gaps = 1'b0;
  logic        pop_stalls = 1'b0;
  int          pop_hold = 0;

  // signed jog speed of one axis, truncating toward zero
  function automatic int axis_speed(logic [7:0] v);
    int x;
    x = v;
    if (x < ZONE_LO) return -(((ZONE_LO - x) * 3) / ZONE_LO);
    if (x > ZONE_HI) return ((x - ZONE_HI) * 3) / (255 - ZONE_HI);
    return 0;
  endfunction

  // min is tested first, so min > max pins the angle to min or max
  function automatic int clamp_deg(int a, int lo, int hi);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic logic [11:0] servo_pulse(int a);
    return 12'(a * 2000 / 360 + 500);
  endfunction

  // advance the jog state by one sample and return the result it must produce
  function automatic out_item_t jog_sample(in_item_t s);
    out_item_t   r;
    logic        moved;
    int          step;
    logic [31:0] elapsed;
    moved = 1'b0;
    step  = jog_cfg.pad_step;
    if (s.stick_x < ZONE_LO || s.stick_x > ZONE_HI) begin
      pan_deg += axis_speed(s.stick_x);
      moved = 1'b1;
    end
    // tilt runs opposite to the stick
    if (s.stick_y < ZONE_LO || s.stick_y > ZONE_HI) begin
      tilt_deg -= axis_speed(s.stick_y);
      moved = 1'b1;
    end
    if (s.pad_left)  begin pan_deg  -= step; moved = 1'b1; end
    if (s.pad_right) begin pan_deg  += step; moved = 1'b1; end
    if (s.pad_up)    begin tilt_deg += step; moved = 1'b1; end
    if (s.pad_down)  begin tilt_deg -= step; moved = 1'b1; end
    // recentre wins over stick and pad motion of the same sample
    if (s.recenter_held) begin
      pan_deg  = jog_cfg.pan_center;
      tilt_deg = jog_cfg.tilt_center;
      moved = 1'b1;
    end
    pan_deg  = clamp_deg(pan_deg, jog_cfg.pan_min, jog_cfg.pan_max);
    tilt_deg = clamp_deg(tilt_deg, jog_cfg.tilt_min, jog_cfg.tilt_max);
    if (moved) begin
      drive_on   = 1'b1;
      move_stamp = s.now_ms;
    end
    // wrapping elapsed time, strictly greater than the timeout disables
    elapsed = s.now_ms - move_stamp;
    if (drive_on && elapsed > 32'(jog_cfg.idle_timeout_ms)) drive_on = 1'b0;
    r.pan_angle_out  = 9'(pan_deg);
    r.tilt_angle_out = 9'(tilt_deg);
    r.pan_pulse_us   = servo_pulse(pan_deg);
    r.tilt_pulse_us  = servo_pulse(tilt_deg);
    r.write_strobe   = moved;
    r.drive_enabled  = drive_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
    end
  endtask

  // every accepted result is held against the oldest owed one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("mismatch: result item with nothing owed at %0t", $realtime);
      end else begin
        want = owed_results.pop_front();
        check_field("pan_angle_out",  want.pan_angle_out,  out_item.pan_angle_out);
        check_field("tilt_angle_out", want.tilt_angle_out, out_item.tilt_angle_out);
        check_field("pan_pulse_us",   want.pan_pulse_us,   out_item.pan_pulse_us);
        check_field("tilt_pulse_us",  want.tilt_pulse_us,  out_item.tilt_pulse_us);
        check_field("write_strobe",   want.write_strobe,   out_item.write_strobe);
        check_field("drive_enabled",  want.drive_enabled,  out_item.drive_enabled);
      end
    end
  end

  // receiver: pops every cycle, or stalls at random with mostly short holds
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!pop_stalls || r < 70) begin
      pop <= 1'b1;
    end else begin
      pop <= 1'b0;
      pop_hold <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  // watchdog: cycles in which no handshake of any kind completes
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driving helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one sample, predict its result once it is taken
  task automatic send_sample(in_item_t s);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    = 1'b1;
    in_item = s;
    do @(posedge clk); while (full);
    owed_results.push_back(jog_sample(s));
    @(negedge clk);
  endtask

  // stop sending and let every owed result come out, plus the pipeline depth
  task automatic wait_drained();
    push = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // register write followed by a readback of the kept bits
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    logic [31:0] kept;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PAN_CENTER:  jog_cfg.pan_center      = val[8:0];
      REG_PAN_MIN:     jog_cfg.pan_min         = val[8:0];
      REG_PAN_MAX:     jog_cfg.pan_max         = val[8:0];
      REG_TILT_CENTER: jog_cfg.tilt_center     = val[8:0];
      REG_TILT_MIN:    jog_cfg.tilt_min        = val[8:0];
      REG_TILT_MAX:    jog_cfg.tilt_max        = val[8:0];
      REG_IDLE_TMO:    jog_cfg.idle_timeout_ms = val[15:0];
      default:         jog_cfg.pad_step        = val[3:0];
    endcase
    if (idx == REG_IDLE_TMO)      kept = {16'd0, val[15:0]};
    else if (idx == REG_PAD_STEP) kept = {28'd0, val[3:0]};
    else                          kept = {23'd0, val[8:0]};
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", kept, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_limits(logic [31:0] pc, logic [31:0] pmin, logic [31:0] pmax,
                              logic [31:0] tc, logic [31:0] tmin, logic [31:0] tmax,
                              logic [31:0] tmo, logic [31:0] step);
    write_reg(REG_PAN_CENTER,  pc);
    write_reg(REG_PAN_MIN,     pmin);
    write_reg(REG_PAN_MAX,     pmax);
    write_reg(REG_TILT_CENTER, tc);
    write_reg(REG_TILT_MIN,    tmin);
    write_reg(REG_TILT_MAX,    tmax);
    write_reg(REG_IDLE_TMO,    tmo);
    write_reg(REG_PAD_STEP,    step);
  endtask

  // pads packed as {left, right, up, down, recentre}
  function automatic in_item_t sample_of(logic [7:0] sx, logic [7:0] sy,
                                         logic [4:0] pads, logic [31:0] now);
    in_item_t s;
    s.stick_x       = sx;
    s.stick_y       = sy;
    s.pad_left      = pads[4];
    s.pad_right     = pads[3];
    s.pad_up        = pads[2];
    s.pad_down      = pads[1];
    s.recenter_held = pads[0];
    s.now_ms        = now;
    return s;
  endfunction

  function automatic logic [7:0] pick_stick(logic still);
    int r;
    r = $urandom_range(0, 99);
    if (still || r < 55) return 8'($urandom_range(ZONE_LO, ZONE_HI));
    if (r < 65) return 8'($urandom_range(ZONE_LO - 2, ZONE_HI + 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // random sample with a mostly advancing time stamp that often lands on the
  // idle boundary; a good share of samples carry no activity at all
  function automatic in_item_t random_sample();
    in_item_t s;
    int       r;
    logic     still;
    logic [31:0] tmo;
    still = ($urandom_range(0, 99) < 40);
    tmo   = jog_cfg.idle_timeout_ms;
    s.stick_x       = pick_stick(still);
    s.stick_y       = pick_stick(still);
    s.pad_left      = !still && ($urandom_range(0, 99) < 15);
    s.pad_right     = !still && ($urandom_range(0, 99) < 15);
    s.pad_up        = !still && ($urandom_range(0, 99) < 15);
    s.pad_down      = !still && ($urandom_range(0, 99) < 15);
    s.recenter_held = !still && ($urandom_range(0, 99) < 6);
    r = $urandom_range(0, 99);
    if (r < 50)      sample_clock += 32'($urandom_range(0, 40));
    else if (r < 75) sample_clock += 32'($urandom_range(0, 2 * tmo + 2));
    else if (r < 94) sample_clock = move_stamp + tmo + 32'($urandom_range(0, 2)) - 32'd1;
    else             sample_clock = $urandom;
    s.now_ms = sample_clock;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: dead zone edges, each pad, recentre, idle boundary, stamp wrap
  task automatic test_directed();
    send_sample(sample_of(128, 128, 5'b00000, 0));
    send_sample(sample_of(0,   128, 5'b00000, 10));   // full left
    send_sample(sample_of(255, 128, 5'b00000, 20));   // full right
    send_sample(sample_of(97,  128, 5'b00000, 30));   // just outside, zero speed
    send_sample(sample_of(98,  128, 5'b00000, 40));   // zone edge, quiet
    send_sample(sample_of(158, 158, 5'b00000, 50));
    send_sample(sample_of(159, 128, 5'b00000, 60));
    send_sample(sample_of(128, 0,   5'b00000, 70));
    send_sample(sample_of(128, 255, 5'b00000, 80));
    send_sample(sample_of(128, 97,  5'b00000, 90));
    send_sample(sample_of(128, 128, 5'b10000, 100));
    send_sample(sample_of(128, 128, 5'b01000, 110));
    send_sample(sample_of(128, 128, 5'b00100, 120));
    send_sample(sample_of(128, 128, 5'b00010, 130));
    send_sample(sample_of(0,   255, 5'b11111, 140));  // recentre beats all motion
    send_sample(sample_of(128, 128, 5'b00001, 150));
    // elapsed equal to the timeout keeps the drive, one more disables it
    send_sample(sample_of(128, 128, 5'b00000, move_stamp + jog_cfg.idle_timeout_ms));
    send_sample(sample_of(128, 128, 5'b00000, move_stamp + jog_cfg.idle_timeout_ms + 1));
    send_sample(sample_of(128, 128, 5'b00000, move_stamp + 5));
    send_sample(sample_of(200, 128, 5'b00000, 32'h8000_0000));  // activity re-enables
    send_sample(sample_of(128, 128, 5'b00000, 32'hFFFF_FFFF));
    send_sample(sample_of(128, 128, 5'b01000, 32'hFFFF_FFFF));
    send_sample(sample_of(128, 128, 5'b00000, 32'h0000_0000));  // wrapped elapsed of one
    wait_drained();
  endtask

  // all-zero registers, all-ones registers (limits past 360), min above max
  task automatic test_register_extremes();
    send_gaps  = 1'b1;
    pop_stalls = 1'b1;
    write_limits(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (20) send_sample(random_sample());
    wait_drained();
    write_limits('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (20) send_sample(random_sample());
    wait_drained();
    write_limits(200, 300, 100, 30, 200, 50, 20, 7);
    repeat (20) send_sample(random_sample());
    wait_drained();
  endtask

  // random limits per phase, pacing varied from phase to phase
  task automatic test_random_traffic();
    int lo_p, hi_p, lo_t, hi_t, tmo;
    for (int phase = 0; phase < 6; phase++) begin
      lo_p = $urandom_range(0, 360);
      hi_p = $urandom_range(lo_p, 360);
      lo_t = $urandom_range(0, 360);
      hi_t = $urandom_range(lo_t, 360);
      if ($urandom_range(0, 9) == 0) begin
        // occasionally inverted window
        lo_p = hi_p + $urandom_range(1, 100);
      end
      tmo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
      write_limits($urandom_range(0, 400), lo_p, hi_p, $urandom_range(0, 400), lo_t, hi_t,
                   tmo, $urandom_range(0, 15));
      send_gaps  = (phase != 0);
      pop_stalls = (phase != 0) && (phase != 2);
      repeat (118) send_sample(random_sample());
      wait_drained();
    end
  endtask

  // heavy receiver stalls back the queues up, then the sender holds off until
  // every owed result is out before a second burst
  task automatic test_drain_pause();
    send_gaps  = 1'b0;
    pop_stalls = 1'b1;
    write_limits(RST_PAN_CENTER, RST_PAN_MIN, RST_PAN_MAX, RST_TILT_CENTER,
                 RST_TILT_MIN, RST_TILT_MAX, 50, RST_PAD_STEP);
    repeat (40) send_sample(random_sample());
    wait_drained();
    repeat (20) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_drain_pause();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/jptj_pkg.sv
hdl/jptj_queue.sv
hdl/jptj_front.sv
hdl/jptj_back.sv
hdl/joystick_pan_tilt_jog.sv
dv/tb.sv
